// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Field widths, character codes, item kinds, and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   localparam int KIND_W = 3;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;

   localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   localparam int TAB_STOP = 4;
   localparam int CNT_W    = $clog2(TAB_STOP + 1);

   // item kinds
   localparam logic [KIND_W-1:0] KIND_PUT       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LEFT      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RIGHT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;

   // cursor operations
   localparam logic [2:0] CUR_HOLD     = 3'd0;
   localparam logic [2:0] CUR_BACK     = 3'd1;
   localparam logic [2:0] CUR_RIGHT    = 3'd2;
   localparam logic [2:0] CUR_COL0     = 3'd3;
   localparam logic [2:0] CUR_NEXT_ROW = 3'd4;
   localparam logic [2:0] CUR_ORIGIN   = 3'd5;

   // repeat counter operations
   localparam logic [1:0] CNT_HOLD  = 2'd0;
   localparam logic [1:0] CNT_CLEAR = 2'd1;
   localparam logic [1:0] CNT_LOAD  = 2'd2;
   localparam logic [1:0] CNT_DEC   = 2'd3;

   // sweep pointer operations
   localparam logic [2:0] PTR_HOLD        = 3'd0;
   localparam logic [2:0] PTR_INC         = 3'd1;
   localparam logic [2:0] PTR_ZERO        = 3'd2;
   localparam logic [2:0] PTR_COPY_START  = 3'd3;
   localparam logic [2:0] PTR_BLANK_START = 3'd4;

   // store write operations
   localparam logic [2:0] WR_NONE       = 3'd0;
   localparam logic [2:0] WR_FILL_INIT  = 3'd1;
   localparam logic [2:0] WR_FILL       = 3'd2;
   localparam logic [2:0] WR_COPY       = 3'd3;
   localparam logic [2:0] WR_CHAR       = 3'd4;
   localparam logic [2:0] WR_BACK_BLANK = 3'd5;

   // store read address select
   localparam logic [1:0] RD_CURSOR = 2'd0;
   localparam logic [1:0] RD_PTR    = 2'd1;
   localparam logic [1:0] RD_ITEM   = 2'd2;

   typedef struct packed {
      logic       latch;
      logic [2:0] cur_op;
      logic [1:0] cnt_op;
      logic [2:0] ptr_op;
      logic [2:0] wr_op;
      logic [1:0] rd_sel;
      logic       capture;
   } tcw_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              is_lf;
      logic              is_cr;
      logic              is_tab;
      logic              col_last;
      logic              row_last;
      logic              cnt_last;
      logic              cnt_zero;
      logic              ptr_first;
      logic              ptr_end;
      logic              ptr_last;
      logic              rsp_free;
   } tcw_status_type;

endpackage

// File: design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: teletype console over a text cell store
// Each item is accepted, executed, its cell read and the result registered;
// a plain character adds a store step, a tab stores blanks up to the next tab
// stop, a scroll adds a copy sweep and a row blanking, a clear a fill sweep.
// One item at a time; the next item is taken the cycle after the result enters
// the output register. After reset a blanking pass fills the store.
// ----------------------------------------------------------------------------
//
// Throughput is set by the sequencer and the single write port of the cell
// store: a printable character needs a write and a read of the addressed cell,
// and no new item is taken before its result is registered. Scroll copies one cell
// per cycle through the registered read port, then blanks the last row.
//
// Reset: the cursor goes to the top-left corner, the attribute to 7, and
// the blanking pass writes space with attribute 7 into every cell; no item
// is taken during the pass, attribute writes are taken at any time.
module text_console_writer #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   // item channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tcw_pkg::KIND_W-1:0]  req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]   req_cell_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_cell_column,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_column,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_read_character,
   output logic [tcw_pkg::ATTR_W-1:0]  rsp_read_attribute,
   // attribute register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_color_attribute
);

   tcw_pkg::tcw_cmd_type    cmd;
   tcw_pkg::tcw_status_type sts;

   // the attribute register never pushes back
   assign csr_ready = 1'b1;

   // sequencer: owns the item handshake and drives the datapath commands
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: cursor, cell store and the result register
   tcw_dp #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_cell_row        (req_cell_row),
      .req_cell_column     (req_cell_column),
      .csr_valid           (csr_valid),
      .csr_color_attribute (csr_color_attribute),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_read_character  (rsp_read_character),
      .rsp_read_attribute  (rsp_read_attribute)
   );

endmodule

// File: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = tcw_pkg::CELL_W,
   parameter int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp: console datapath
// Cursor, item fields, attribute register, sweep pointer, cell store and
// the result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
   parameter int SCREEN_COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int SCREEN_ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tcw_pkg::tcw_cmd_type        cmd,
   output tcw_pkg::tcw_status_type     sts,
   input  logic [tcw_pkg::KIND_W-1:0]  req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]   req_cell_row,
   input  logic [tcw_pkg::COL_W-1:0]   req_cell_column,
   input  logic                        csr_valid,
   input  logic [tcw_pkg::ATTR_W-1:0]  csr_color_attribute,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [tcw_pkg::ROW_W-1:0]   rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]   rsp_cursor_column,
   output logic [tcw_pkg::CHAR_W-1:0]  rsp_read_character,
   output logic [tcw_pkg::ATTR_W-1:0]  rsp_read_attribute
);

   localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(SCREEN_ROWS);
   localparam int CW    = $clog2(SCREEN_COLUMNS);
   localparam int OROW  = tcw_pkg::ROW_W;
   localparam int OCOL  = tcw_pkg::COL_W;
   localparam int CNTW  = tcw_pkg::CNT_W;
   localparam int CHW   = tcw_pkg::CHAR_W;
   localparam int ATW   = tcw_pkg::ATTR_W;

   // item fields
   logic [tcw_pkg::KIND_W-1:0] kind_ff;
   logic [CHW-1:0]             ch_ff;
   logic [OROW-1:0]            req_row_ff;
   logic [OCOL-1:0]            req_col_ff;

   // control state
   logic [RW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]   ptr_ff, ptr_in;
   logic [ATW-1:0]  attr_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [OROW-1:0] rsp_row_ff;
   logic [OCOL-1:0] rsp_col_ff;
   logic [CHW-1:0]  rsp_char_ff;
   logic [ATW-1:0]  rsp_attr_ff;

   logic [RW-1:0]   back_row;
   logic [CW-1:0]   back_col;
   logic [AW-1:0]   cur_addr, back_addr, req_addr;
   logic            req_ok, out_blank;
   logic [CHW-1:0]  store_ch;
   logic [CNTW-1:0] load_cnt;

   logic                       ram_we;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   always_comb begin
      back_row = row_ff;
      back_col = col_ff;
      if (col_ff != '0) begin
         back_col = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         back_row = row_ff - 1'b1;
         back_col = CW'(SCREEN_COLUMNS - 1);
      end
   end

   assign cur_addr  = AW'(32'(row_ff) * SCREEN_COLUMNS + 32'(col_ff));
   assign back_addr = AW'(32'(back_row) * SCREEN_COLUMNS + 32'(back_col));
   assign req_addr  = AW'(32'(req_row_ff) * SCREEN_COLUMNS + 32'(req_col_ff));
   assign req_ok    = (32'(req_row_ff) < SCREEN_ROWS) && (32'(req_col_ff) < SCREEN_COLUMNS);
   assign out_blank = (kind_ff == tcw_pkg::KIND_READ) && !req_ok;

   assign store_ch = sts.is_tab ? tcw_pkg::BLANK_CHAR : ch_ff;
   assign load_cnt = sts.is_tab ? CNTW'(tcw_pkg::TAB_STOP - 32'(col_ff % tcw_pkg::TAB_STOP))
                                : CNTW'(1);

   // status toward the controller
   always_comb begin
      sts.kind      = kind_ff;
      sts.is_lf     = (ch_ff == tcw_pkg::CH_LF);
      sts.is_cr     = (ch_ff == tcw_pkg::CH_CR);
      sts.is_tab    = (ch_ff == tcw_pkg::CH_TAB);
      sts.col_last  = (col_ff == CW'(SCREEN_COLUMNS - 1));
      sts.row_last  = (row_ff == RW'(SCREEN_ROWS - 1));
      sts.cnt_last  = (cnt_ff == CNTW'(1));
      sts.cnt_zero  = (cnt_ff == '0);
      sts.ptr_first = (ptr_ff == PW'(SCREEN_COLUMNS));
      sts.ptr_end   = (ptr_ff == PW'(CELLS));
      sts.ptr_last  = (ptr_ff == PW'(CELLS - 1));
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // cursor
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      case (cmd.cur_op)
         tcw_pkg::CUR_HOLD: begin
         end
         tcw_pkg::CUR_BACK: begin
            row_in = back_row;
            col_in = back_col;
         end
         tcw_pkg::CUR_RIGHT: begin
            col_in = col_ff + 1'b1;
         end
         tcw_pkg::CUR_COL0: begin
            col_in = '0;
         end
         tcw_pkg::CUR_NEXT_ROW: begin
            row_in = row_ff + 1'b1;
            col_in = '0;
         end
         tcw_pkg::CUR_ORIGIN: begin
            row_in = '0;
            col_in = '0;
         end
         default: begin
         end
      endcase
   end

   // repeat counter and sweep pointer
   always_comb begin
      cnt_in = cnt_ff;
      case (cmd.cnt_op)
         tcw_pkg::CNT_CLEAR: cnt_in = '0;
         tcw_pkg::CNT_LOAD:  cnt_in = load_cnt;
         tcw_pkg::CNT_DEC:   cnt_in = cnt_ff - 1'b1;
         default:            cnt_in = cnt_ff;
      endcase
      ptr_in = ptr_ff;
      case (cmd.ptr_op)
         tcw_pkg::PTR_INC:         ptr_in = ptr_ff + 1'b1;
         tcw_pkg::PTR_ZERO:        ptr_in = '0;
         tcw_pkg::PTR_COPY_START:  ptr_in = PW'(SCREEN_COLUMNS);
         tcw_pkg::PTR_BLANK_START: ptr_in = PW'(CELLS - SCREEN_COLUMNS);
         default:                  ptr_in = ptr_ff;
      endcase
   end

   // store ports
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ptr_ff[AW-1:0];
      ram_wdata = {tcw_pkg::BLANK_CHAR, attr_ff};
      case (cmd.wr_op)
         tcw_pkg::WR_FILL_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = {tcw_pkg::BLANK_CHAR, tcw_pkg::RESET_ATTR};
         end
         tcw_pkg::WR_FILL: begin
            ram_we = 1'b1;
         end
         tcw_pkg::WR_COPY: begin
            // data read in the previous cycle lands one row up
            ram_we    = 1'b1;
            ram_waddr = AW'(ptr_ff - PW'(SCREEN_COLUMNS + 1));
            ram_wdata = ram_rdata;
         end
         tcw_pkg::WR_CHAR: begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = {store_ch, attr_ff};
         end
         tcw_pkg::WR_BACK_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = back_addr;
         end
         default: begin
         end
      endcase
      case (cmd.rd_sel)
         tcw_pkg::RD_PTR:  ram_raddr = ptr_ff[AW-1:0];
         tcw_pkg::RD_ITEM: ram_raddr = (kind_ff == tcw_pkg::KIND_READ) ? req_addr : cur_addr;
         default:          ram_raddr = cur_addr;
      endcase
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid_in = cmd.capture || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         attr_ff      <= tcw_pkg::RESET_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            attr_ff <= csr_color_attribute;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff    <= req_kind;
         ch_ff      <= req_char_code;
         req_row_ff <= req_cell_row;
         req_col_ff <= req_cell_column;
      end
      if (cmd.capture) begin
         rsp_row_ff  <= OROW'(row_ff);
         rsp_col_ff  <= OCOL'(col_ff);
         rsp_char_ff <= out_blank ? '0 : ram_rdata[tcw_pkg::CELL_W-1:ATW];
         rsp_attr_ff <= out_blank ? '0 : ram_rdata[ATW-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_row     = rsp_row_ff;
   assign rsp_cursor_column  = rsp_col_ff;
   assign rsp_read_character = rsp_char_ff;
   assign rsp_read_attribute = rsp_attr_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(row_ff) < SCREEN_ROWS) && (32'(col_ff) < SCREEN_COLUMNS))
      else $error("cursor outside the screen");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < CELLS))
      else $error("store write outside the screen");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == tcw_pkg::CNT_DEC) |-> (cnt_ff != '0))
      else $error("repeat counter underflow");

   a_capture_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid_ff)
      else $error("captured item not presented");

endmodule

// File: design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl: console sequencer
// Steps each item through store writes, scroll and clear sweeps, and the
// final cell read; runs the blanking pass after reset.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tcw_pkg::tcw_status_type sts,
   output tcw_pkg::tcw_cmd_type    cmd
);

   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_EXEC   = 4'd2;
   localparam logic [3:0] S_STORE  = 4'd3;
   localparam logic [3:0] S_SCROLL = 4'd4;
   localparam logic [3:0] S_BLANK  = 4'd5;
   localparam logic [3:0] S_CLEAR  = 4'd6;
   localparam logic [3:0] S_READ   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.wr_op  = tcw_pkg::WR_FILL_INIT;
            cmd.ptr_op = tcw_pkg::PTR_INC;
            if (sts.ptr_last) begin
               cmd.ptr_op = tcw_pkg::PTR_ZERO;
               state_in   = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch  = 1'b1;
               cmd.cnt_op = tcw_pkg::CNT_CLEAR;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_READ;
            case (sts.kind)
               tcw_pkg::KIND_PUT: begin
                  if (sts.is_lf) begin
                     if (!sts.row_last) begin
                        cmd.cur_op = tcw_pkg::CUR_NEXT_ROW;
                     end else begin
                        cmd.cur_op = tcw_pkg::CUR_COL0;
                        cmd.ptr_op = tcw_pkg::PTR_COPY_START;
                        state_in   = S_SCROLL;
                     end
                  end else if (sts.is_cr) begin
                     cmd.cur_op = tcw_pkg::CUR_COL0;
                  end else begin
                     cmd.cnt_op = tcw_pkg::CNT_LOAD;
                     state_in   = S_STORE;
                  end
               end
               tcw_pkg::KIND_LEFT: begin
                  cmd.cur_op = tcw_pkg::CUR_BACK;
               end
               tcw_pkg::KIND_RIGHT: begin
                  if (!sts.col_last) begin
                     cmd.cur_op = tcw_pkg::CUR_RIGHT;
                  end else if (!sts.row_last) begin
                     cmd.cur_op = tcw_pkg::CUR_NEXT_ROW;
                  end else begin
                     cmd.cur_op = tcw_pkg::CUR_COL0;
                     cmd.ptr_op = tcw_pkg::PTR_COPY_START;
                     state_in   = S_SCROLL;
                  end
               end
               tcw_pkg::KIND_BACKSPACE: begin
                  cmd.wr_op  = tcw_pkg::WR_BACK_BLANK;
                  cmd.cur_op = tcw_pkg::CUR_BACK;
               end
               tcw_pkg::KIND_CLEAR: begin
                  cmd.ptr_op = tcw_pkg::PTR_ZERO;
                  state_in   = S_CLEAR;
               end
               default: begin
               end
            endcase
         end
         S_STORE: begin
            // one character per cycle while no scroll runs; a row end wraps or scrolls
            cmd.wr_op  = tcw_pkg::WR_CHAR;
            cmd.cnt_op = tcw_pkg::CNT_DEC;
            state_in   = sts.cnt_last ? S_READ : S_STORE;
            if (!sts.col_last) begin
               cmd.cur_op = tcw_pkg::CUR_RIGHT;
            end else if (!sts.row_last) begin
               cmd.cur_op = tcw_pkg::CUR_NEXT_ROW;
            end else begin
               cmd.cur_op = tcw_pkg::CUR_COL0;
               cmd.ptr_op = tcw_pkg::PTR_COPY_START;
               state_in   = S_SCROLL;
            end
         end
         S_SCROLL: begin
            cmd.rd_sel = sts.ptr_end ? tcw_pkg::RD_CURSOR : tcw_pkg::RD_PTR;
            if (!sts.ptr_first) begin
               cmd.wr_op = tcw_pkg::WR_COPY;
            end
            if (sts.ptr_end) begin
               cmd.ptr_op = tcw_pkg::PTR_BLANK_START;
               state_in   = S_BLANK;
            end else begin
               cmd.ptr_op = tcw_pkg::PTR_INC;
            end
         end
         S_BLANK: begin
            cmd.wr_op  = tcw_pkg::WR_FILL;
            cmd.ptr_op = tcw_pkg::PTR_INC;
            if (sts.ptr_last) begin
               state_in = sts.cnt_zero ? S_READ : S_STORE;
            end
         end
         S_CLEAR: begin
            cmd.wr_op  = tcw_pkg::WR_FILL;
            cmd.ptr_op = tcw_pkg::PTR_INC;
            if (sts.ptr_last) begin
               cmd.ptr_op = tcw_pkg::PTR_ZERO;
               cmd.cur_op = tcw_pkg::CUR_ORIGIN;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_sel = tcw_pkg::RD_ITEM;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // keep the read address so the cell stays on the read port
            cmd.rd_sel = tcw_pkg::RD_ITEM;
            if (sts.rsp_free) begin
               cmd.capture = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scroll_to_blank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && sts.ptr_end) |=> (state_ff == S_BLANK))
      else $error("scroll did not hand over to row blanking");

   a_sweep_no_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT || state_ff == S_CLEAR || state_ff == S_SCROLL) |-> !cmd.latch)
      else $error("item taken during a store sweep");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !sts.rsp_free) |=> (state_ff == S_DONE))
      else $error("result dropped while output busy");

endmodule
